// ===== rtl/core/xmcrc_pkg.sv =====
// Shared types, byte codes and the CRC-16 byte update for the XMODEM-CRC/1K receiver.
// No dependencies; every other file of the receiver uses this package by scoped names.

package xmcrc_pkg;

   // Packet sizes
   localparam int LONG_PACKET_BYTES  = 1024;
   localparam int SHORT_PACKET_BYTES = 128;
   localparam int COUNT_WIDTH        = $clog2(LONG_PACKET_BYTES + 1);
   localparam int OFFSET_WIDTH       = 10;

   // Protocol bytes
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_C   = 8'h43;

   // Input transaction kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // Session status
   localparam logic [1:0] SESSION_RUNNING  = 2'd0;
   localparam logic [1:0] SESSION_COMPLETE = 2'd1;
   localparam logic [1:0] SESSION_ABORTED  = 2'd2;

   // Register map
   localparam logic CSR_MAX_ERRORS    = 1'b0;
   localparam logic CSR_START_ADDRESS = 1'b1;

   localparam logic [7:0]  MAX_ERRORS_RESET    = 8'd3;
   localparam logic [31:0] START_ADDRESS_RESET = 32'd0;
   localparam logic [7:0]  ERROR_COUNT_MAX     = 8'd255;
   localparam logic [8:0]  COMPLEMENT_SUM      = 9'd255;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // One result transaction
   typedef struct packed {
      logic                    data_valid;
      logic [7:0]              data_byte;
      logic [OFFSET_WIDTH-1:0] data_offset;
      logic                    reply_valid;
      logic [7:0]              reply_byte;
      logic                    packet_end;
      logic                    packet_ok;
      logic                    erase_request;
      logic [31:0]             packet_address;
      logic [1:0]              session;
      logic                    last;
   } result_type;

   // What one processed item produces
   typedef struct packed {
      logic       has_result;
      logic       has_second;
      result_type first;
   } step_type;

   // CRC-16/XMODEM update by one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/xmcrc_engine.sv =====
// Session state and per-item step logic of the XMODEM-CRC/1K receiver.
// Depends on xmcrc_pkg; instantiated by xmodem_crc_receiver_core.

module xmcrc_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  logic [1:0]               kind,
   input  logic [7:0]               byte_value,
   input  logic [7:0]               max_errors,
   input  logic [31:0]              start_address,
   output xmcrc_pkg::step_type      step
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_NUM    = 3'd1;
   localparam logic [2:0] PH_COMP   = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CRC_HI = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;
   localparam logic [2:0] PH_ENDED  = 3'd6;

   localparam int CW = xmcrc_pkg::COUNT_WIDTH;

   logic [2:0]    phase_ff, phase_in;
   logic          first_seen_ff, first_seen_in;
   logic          long_packet_ff, long_packet_in;
   logic [7:0]    expected_ff, expected_in;
   logic [31:0]   write_address_ff, write_address_in;
   logic [7:0]    error_count_ff, error_count_in;
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    number_ff, number_in;
   logic [7:0]    complement_ff, complement_in;
   logic [7:0]    crc_high_ff, crc_high_in;
   logic [1:0]    ended_ff, ended_in;

   logic [7:0]    error_inc;
   logic [CW-1:0] count_next;
   logic [CW-1:0] packet_size;
   logic          packet_good;
   logic          end_packet;
   logic          end_ok;
   logic          error_hit;

   // Shared terms of the step
   always_comb begin
      error_inc   = (error_count_ff < xmcrc_pkg::ERROR_COUNT_MAX) ?
                    error_count_ff + 8'd1 : error_count_ff;
      count_next  = byte_count_ff + CW'(1);
      packet_size = long_packet_ff ? CW'(xmcrc_pkg::LONG_PACKET_BYTES) :
                                     CW'(xmcrc_pkg::SHORT_PACKET_BYTES);
      packet_good = (number_ff == expected_ff) &&
                    (({1'b0, number_ff} + {1'b0, complement_ff}) ==
                     xmcrc_pkg::COMPLEMENT_SUM) &&
                    ({crc_high_ff, byte_value} == crc_ff);
   end

   // Next state and results of one item
   always_comb begin
      phase_in         = phase_ff;
      first_seen_in    = first_seen_ff;
      long_packet_in   = long_packet_ff;
      expected_in      = expected_ff;
      write_address_in = write_address_ff;
      error_count_in   = error_count_ff;
      byte_count_in    = byte_count_ff;
      crc_in           = crc_ff;
      number_in        = number_ff;
      complement_in    = complement_ff;
      crc_high_in      = crc_high_ff;
      ended_in         = ended_ff;
      step             = '0;
      end_packet       = 1'b0;
      end_ok           = 1'b0;
      error_hit        = 1'b0;

      if (kind == xmcrc_pkg::KIND_RESTART) begin
         phase_in         = PH_HEADER;
         first_seen_in    = 1'b0;
         long_packet_in   = 1'b0;
         expected_in      = 8'd1;
         write_address_in = start_address;
         error_count_in   = 8'd0;
         byte_count_in    = '0;
         crc_in           = 16'd0;
         number_in        = 8'd0;
         complement_in    = 8'd0;
         crc_high_in      = 8'd0;
         ended_in         = xmcrc_pkg::SESSION_RUNNING;
      end else if (kind == xmcrc_pkg::KIND_TIMEOUT && phase_ff != PH_ENDED) begin
         if (phase_ff == PH_HEADER) begin
            if (!first_seen_ff) begin
               step.has_result        = 1'b1;
               step.first.reply_valid = 1'b1;
               step.first.reply_byte  = xmcrc_pkg::BYTE_C;
            end
         end else begin
            end_packet = 1'b1;
         end
      end else if (kind == xmcrc_pkg::KIND_BYTE && phase_ff != PH_ENDED) begin
         case (phase_ff)
            PH_HEADER: begin
               if (byte_value == xmcrc_pkg::BYTE_SOH || byte_value == xmcrc_pkg::BYTE_STX) begin
                  first_seen_in  = 1'b1;
                  long_packet_in = (byte_value == xmcrc_pkg::BYTE_STX);
                  byte_count_in  = '0;
                  crc_in         = 16'd0;
                  phase_in       = PH_NUM;
               end else if (byte_value == xmcrc_pkg::BYTE_EOT) begin
                  step.has_result        = 1'b1;
                  step.first.reply_valid = 1'b1;
                  step.first.reply_byte  = xmcrc_pkg::BYTE_ACK;
                  ended_in               = xmcrc_pkg::SESSION_COMPLETE;
                  phase_in               = PH_ENDED;
               end else if (byte_value == xmcrc_pkg::BYTE_CAN) begin
                  ended_in = xmcrc_pkg::SESSION_ABORTED;
                  phase_in = PH_ENDED;
               end else begin
                  error_hit = 1'b1;
               end
            end
            PH_NUM: begin
               number_in = byte_value;
               phase_in  = PH_COMP;
            end
            PH_COMP: begin
               complement_in = byte_value;
               phase_in      = PH_DATA;
            end
            PH_DATA: begin
               step.has_result       = 1'b1;
               step.first.data_valid = 1'b1;
               step.first.data_byte  = byte_value;
               step.first.data_offset = byte_count_ff[xmcrc_pkg::OFFSET_WIDTH-1:0];
               crc_in        = xmcrc_pkg::crc_byte(crc_ff, byte_value);
               byte_count_in = count_next;
               if (count_next >= packet_size) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               crc_high_in = byte_value;
               phase_in    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               end_packet = 1'b1;
               end_ok     = packet_good;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // Packet end: commit fields, then ACK or an error verdict
      if (end_packet) begin
         step.has_result           = 1'b1;
         step.first.packet_end     = 1'b1;
         step.first.packet_ok      = end_ok;
         step.first.erase_request  = (expected_ff[1:0] == 2'd1);
         step.first.packet_address = write_address_ff;
         if (end_ok) begin
            step.first.reply_valid = 1'b1;
            step.first.reply_byte  = xmcrc_pkg::BYTE_ACK;
            expected_in      = expected_ff + 8'd1;
            write_address_in = write_address_ff +
                               (long_packet_ff ? 32'(xmcrc_pkg::LONG_PACKET_BYTES) :
                                                 32'(xmcrc_pkg::SHORT_PACKET_BYTES));
            phase_in         = PH_HEADER;
         end else begin
            error_hit = 1'b1;
         end
      end

      // Error verdict: NAK, or CAN CAN at the limit
      if (error_hit) begin
         step.has_result        = 1'b1;
         step.first.reply_valid = 1'b1;
         error_count_in         = error_inc;
         if (error_inc >= max_errors) begin
            step.has_second       = 1'b1;
            step.first.reply_byte = xmcrc_pkg::BYTE_CAN;
            ended_in              = xmcrc_pkg::SESSION_ABORTED;
            phase_in              = PH_ENDED;
         end else begin
            step.first.reply_byte = xmcrc_pkg::BYTE_NAK;
            phase_in              = PH_HEADER;
         end
      end

      step.first.session = ended_in;
      step.first.last    = !step.has_second;
   end

   // Session state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         first_seen_ff    <= 1'b0;
         long_packet_ff   <= 1'b0;
         expected_ff      <= 8'd1;
         write_address_ff <= xmcrc_pkg::START_ADDRESS_RESET;
         error_count_ff   <= 8'd0;
         byte_count_ff    <= '0;
         crc_ff           <= 16'd0;
         number_ff        <= 8'd0;
         complement_ff    <= 8'd0;
         crc_high_ff      <= 8'd0;
         ended_ff         <= xmcrc_pkg::SESSION_RUNNING;
      end else if (step_valid) begin
         phase_ff         <= phase_in;
         first_seen_ff    <= first_seen_in;
         long_packet_ff   <= long_packet_in;
         expected_ff      <= expected_in;
         write_address_ff <= write_address_in;
         error_count_ff   <= error_count_in;
         byte_count_ff    <= byte_count_in;
         crc_ff           <= crc_in;
         number_ff        <= number_in;
         complement_ff    <= complement_in;
         crc_high_ff      <= crc_high_in;
         ended_ff         <= ended_in;
      end
   end

endmodule

// ===== rtl/core/xmodem_crc_receiver_core.sv =====
// XMODEM-CRC/1K receiver top level: input register, configuration registers, result register.
// Depends on xmcrc_pkg and xmcrc_engine.
// A result passes through the input register and then the result register before it appears on rsp.
// Throughput: one input transaction per cycle while the result channel does not stall; an item ending
// in CAN CAN holds the input until its second result has been taken from the single result register.
// Reset (synchronous): session state, handshake state and configuration registers return to reset values.

module xmodem_crc_receiver_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [7:0]                           req_byte_value,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_data_valid,
   output logic [7:0]                           rsp_data_byte,
   output logic [xmcrc_pkg::OFFSET_WIDTH-1:0]   rsp_data_offset,
   output logic                                 rsp_reply_valid,
   output logic [7:0]                           rsp_reply_byte,
   output logic                                 rsp_packet_end,
   output logic                                 rsp_packet_ok,
   output logic                                 rsp_erase_request,
   output logic [31:0]                          rsp_packet_address,
   output logic [1:0]                           rsp_session,
   output logic                                 rsp_last,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [31:0]                          csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_kind_ff;
   logic [7:0]  in_byte_ff;
   logic [7:0]  max_errors_ff;
   logic [31:0] start_address_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  second_ff, second_in;
   xmcrc_pkg::result_type rsp_ff, rsp_in;
   xmcrc_pkg::result_type second_result;
   xmcrc_pkg::step_type   step;

   logic req_take;
   logic rsp_take;
   logic out_free;
   logic fire;

   // Handshake control
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || (rsp_take && !second_ff);
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !fire);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff    <= xmcrc_pkg::MAX_ERRORS_RESET;
         start_address_ff <= xmcrc_pkg::START_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            xmcrc_pkg::CSR_MAX_ERRORS:    max_errors_ff    <= csr_write_data[7:0];
            xmcrc_pkg::CSR_START_ADDRESS: start_address_ff <= csr_write_data;
            default:                      max_errors_ff    <= max_errors_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_byte_value;
      end
   end

   xmcrc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (fire),
      .kind          (in_kind_ff),
      .byte_value    (in_byte_ff),
      .max_errors    (max_errors_ff),
      .start_address (start_address_ff),
      .step          (step)
   );

   // Second CAN of an abort
   always_comb begin
      second_result             = '0;
      second_result.reply_valid = 1'b1;
      second_result.reply_byte  = xmcrc_pkg::BYTE_CAN;
      second_result.session     = xmcrc_pkg::SESSION_ABORTED;
      second_result.last        = 1'b1;
   end

   // Result register loading
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      second_in    = second_ff;
      rsp_in       = rsp_ff;
      if (fire && step.has_result) begin
         rsp_valid_in = 1'b1;
         second_in    = step.has_second;
         rsp_in       = step.first;
      end else if (rsp_take && second_ff) begin
         rsp_valid_in = 1'b1;
         second_in    = 1'b0;
         rsp_in       = second_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_valid     = rsp_ff.data_valid;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_data_offset    = rsp_ff.data_offset;
   assign rsp_reply_valid    = rsp_ff.reply_valid;
   assign rsp_reply_byte     = rsp_ff.reply_byte;
   assign rsp_packet_end     = rsp_ff.packet_end;
   assign rsp_packet_ok      = rsp_ff.packet_ok;
   assign rsp_erase_request  = rsp_ff.erase_request;
   assign rsp_packet_address = rsp_ff.packet_address;
   assign rsp_session        = rsp_ff.session;
   assign rsp_last           = rsp_ff.last;

endmodule

// ===== rtl/core/xmcrc_checker.sv =====
// Port-level checks of the XMODEM-CRC/1K receiver, bound to the top level.
// Depends on xmcrc_pkg and xmodem_crc_receiver_core.

module xmcrc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_data_valid,
   input logic [7:0]                         rsp_data_byte,
   input logic                               rsp_reply_valid,
   input logic [7:0]                         rsp_reply_byte,
   input logic                               rsp_packet_end,
   input logic [1:0]                         rsp_session,
   input logic                               rsp_last
);

   // Stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_last) &&
                                 $stable(rsp_reply_byte) && $stable(rsp_data_byte))
      else $error("stalled result changed");

   // Only an abort yields two results, the first being CAN
   a_not_last_is_can: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_reply_valid &&
                                 rsp_reply_byte == xmcrc_pkg::BYTE_CAN &&
                                 rsp_session == xmcrc_pkg::SESSION_ABORTED)
      else $error("non-final result is not CAN");

   // Every packet end carries a verdict
   a_end_has_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_reply_valid)
      else $error("packet end without reply");

   // Payload bytes come alone, in a running session
   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> !rsp_reply_valid && !rsp_packet_end &&
                                      rsp_last &&
                                      rsp_session == xmcrc_pkg::SESSION_RUNNING)
      else $error("payload byte mixed with other fields");

endmodule

bind xmodem_crc_receiver_core xmcrc_checker u_xmcrc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_reply_valid (rsp_reply_valid),
   .rsp_reply_byte  (rsp_reply_byte),
   .rsp_packet_end  (rsp_packet_end),
   .rsp_session     (rsp_session),
   .rsp_last        (rsp_last)
);

// ===== bench/xmodem_crc_receiver_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for xmodem_crc_receiver_core: sends byte, timeout and restart
// transactions and checks every result transaction against a transaction-level model.
// Depends on xmcrc_pkg and the receiver RTL.

module xmodem_crc_receiver_core_tb;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT   = 2000;

   typedef enum logic [2:0] {
      RX_HEADER, RX_NUMBER, RX_COMPLEMENT, RX_DATA, RX_CRC_HIGH, RX_CRC_LOW, RX_ENDED
   } rx_phase_type;

   typedef enum int {FLAW_NONE, FLAW_NUMBER, FLAW_COMPLEMENT, FLAW_CRC, FLAW_TIMEOUT} flaw_type;

   // Receiver model plus queue of expected result transactions
   class transfer_scoreboard;
      logic [7:0]            error_limit  = xmcrc_pkg::MAX_ERRORS_RESET;
      logic [31:0]           base_address = xmcrc_pkg::START_ADDRESS_RESET;
      rx_phase_type          rx_phase;
      bit                    header_seen;
      bit                    long_mode;
      logic [7:0]            next_number;
      logic [31:0]           flash_address;
      logic [7:0]            error_total;
      logic [10:0]           data_count;
      logic [15:0]           running_crc;
      logic [7:0]            got_number;
      logic [7:0]            got_complement;
      logic [7:0]            got_crc_high;
      logic [1:0]            session_state;
      xmcrc_pkg::result_type first_result;
      xmcrc_pkg::result_type second_result;
      int                    produced;
      xmcrc_pkg::result_type expected_results[$];
      int                    mismatch_count;
      int                    checked;

      function new();
         restart_session();
      endfunction

      function bit session_over();
         return rx_phase == RX_ENDED;
      endfunction

      // CRC-16 shift register, poly 0x1021, MSB first
      function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] value);
         logic [15:0] c;
         logic        feedback;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            feedback = c[15] ^ value[i];
            c = {c[14:0], 1'b0};
            if (feedback) begin
               c = c ^ xmcrc_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      function void restart_session();
         rx_phase       = RX_HEADER;
         header_seen    = 1'b0;
         long_mode      = 1'b0;
         next_number    = 8'd1;
         flash_address  = base_address;
         error_total    = '0;
         data_count     = '0;
         running_crc    = '0;
         got_number     = '0;
         got_complement = '0;
         got_crc_high   = '0;
         session_state  = xmcrc_pkg::SESSION_RUNNING;
      endfunction

      // One more error: NAK, or CAN CAN once the limit is reached
      function void count_error();
         if (error_total != xmcrc_pkg::ERROR_COUNT_MAX) begin
            error_total++;
         end
         first_result.reply_valid = 1'b1;
         if (error_total >= error_limit) begin
            first_result.reply_byte   = xmcrc_pkg::BYTE_CAN;
            second_result             = '0;
            second_result.reply_valid = 1'b1;
            second_result.reply_byte  = xmcrc_pkg::BYTE_CAN;
            produced      = 2;
            session_state = xmcrc_pkg::SESSION_ABORTED;
            rx_phase      = RX_ENDED;
         end else begin
            first_result.reply_byte = xmcrc_pkg::BYTE_NAK;
            produced = 1;
            rx_phase = RX_HEADER;
         end
      endfunction

      function void close_packet(bit good);
         first_result.packet_end     = 1'b1;
         first_result.packet_ok      = good;
         first_result.erase_request  = (next_number[1:0] == 2'b01);
         first_result.packet_address = flash_address;
         if (good) begin
            first_result.reply_valid = 1'b1;
            first_result.reply_byte  = xmcrc_pkg::BYTE_ACK;
            next_number++;
            flash_address += long_mode ? xmcrc_pkg::LONG_PACKET_BYTES :
                                         xmcrc_pkg::SHORT_PACKET_BYTES;
            rx_phase = RX_HEADER;
            produced = 1;
         end else begin
            count_error();
         end
      endfunction

      // Accepted input transaction: update the model, queue what it should produce
      function void note_item(logic [1:0] kind, logic [7:0] value);
         logic [10:0] size;
         logic [15:0] rx_crc_word;
         first_result  = '0;
         second_result = '0;
         produced      = 0;
         if (kind == xmcrc_pkg::KIND_RESTART) begin
            restart_session();
            return;
         end
         if (kind == KIND_UNUSED || rx_phase == RX_ENDED) begin
            return;
         end
         size = long_mode ? 11'(xmcrc_pkg::LONG_PACKET_BYTES) :
                            11'(xmcrc_pkg::SHORT_PACKET_BYTES);
         if (kind == xmcrc_pkg::KIND_TIMEOUT) begin
            if (rx_phase != RX_HEADER) begin
               close_packet(1'b0);
            end else if (!header_seen) begin
               first_result.reply_valid = 1'b1;
               first_result.reply_byte  = xmcrc_pkg::BYTE_C;
               produced = 1;
            end
         end else begin
            case (rx_phase)
               RX_HEADER: begin
                  if (value == xmcrc_pkg::BYTE_SOH || value == xmcrc_pkg::BYTE_STX) begin
                     header_seen = 1'b1;
                     long_mode   = (value == xmcrc_pkg::BYTE_STX);
                     data_count  = '0;
                     running_crc = '0;
                     rx_phase    = RX_NUMBER;
                  end else if (value == xmcrc_pkg::BYTE_EOT) begin
                     first_result.reply_valid = 1'b1;
                     first_result.reply_byte  = xmcrc_pkg::BYTE_ACK;
                     produced      = 1;
                     session_state = xmcrc_pkg::SESSION_COMPLETE;
                     rx_phase      = RX_ENDED;
                  end else if (value == xmcrc_pkg::BYTE_CAN) begin
                     session_state = xmcrc_pkg::SESSION_ABORTED;
                     rx_phase      = RX_ENDED;
                  end else begin
                     count_error();
                  end
               end
               RX_NUMBER: begin
                  got_number = value;
                  rx_phase   = RX_COMPLEMENT;
               end
               RX_COMPLEMENT: begin
                  got_complement = value;
                  rx_phase       = RX_DATA;
               end
               RX_DATA: begin
                  first_result.data_valid  = 1'b1;
                  first_result.data_byte   = value;
                  first_result.data_offset = data_count[xmcrc_pkg::OFFSET_WIDTH-1:0];
                  running_crc = crc16_step(running_crc, value);
                  data_count++;
                  if (data_count >= size) begin
                     rx_phase = RX_CRC_HIGH;
                  end
                  produced = 1;
               end
               RX_CRC_HIGH: begin
                  got_crc_high = value;
                  rx_phase     = RX_CRC_LOW;
               end
               default: begin
                  rx_crc_word = {got_crc_high, value};
                  close_packet(got_number == next_number &&
                               {1'b0, got_number} + {1'b0, got_complement} ==
                               xmcrc_pkg::COMPLEMENT_SUM &&
                               rx_crc_word == running_crc);
               end
            endcase
         end
         // session is the value after this transaction; last marks the final result
         first_result.session  = session_state;
         second_result.session = session_state;
         if (produced == 2) begin
            second_result.last = 1'b1;
            expected_results.push_back(first_result);
            expected_results.push_back(second_result);
         end else if (produced == 1) begin
            first_result.last = 1'b1;
            expected_results.push_back(first_result);
         end
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      checked, name, got, want));
         end
      endtask

      task check_result(xmcrc_pkg::result_type got);
         xmcrc_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
            checked++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("data_valid", 32'(got.data_valid), 32'(want.data_valid));
         compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
         compare_field("data_offset", 32'(got.data_offset), 32'(want.data_offset));
         compare_field("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
         compare_field("reply_byte", 32'(got.reply_byte), 32'(want.reply_byte));
         compare_field("packet_end", 32'(got.packet_end), 32'(want.packet_end));
         compare_field("packet_ok", 32'(got.packet_ok), 32'(want.packet_ok));
         compare_field("erase_request", 32'(got.erase_request), 32'(want.erase_request));
         compare_field("packet_address", got.packet_address, want.packet_address);
         compare_field("session", 32'(got.session), 32'(want.session));
         compare_field("last", 32'(got.last), 32'(want.last));
         checked++;
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [1:0]                         req_kind = xmcrc_pkg::KIND_BYTE;
   logic [7:0]                         req_byte_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_data_valid;
   logic [7:0]                         rsp_data_byte;
   logic [xmcrc_pkg::OFFSET_WIDTH-1:0] rsp_data_offset;
   logic                               rsp_reply_valid;
   logic [7:0]                         rsp_reply_byte;
   logic                               rsp_packet_end;
   logic                               rsp_packet_ok;
   logic                               rsp_erase_request;
   logic [31:0]                        rsp_packet_address;
   logic [1:0]                         rsp_session;
   logic                               rsp_last;
   logic                               csr_write_enable = 1'b0;
   logic                               csr_index = xmcrc_pkg::CSR_MAX_ERRORS;
   logic [31:0]                        csr_write_data = '0;

   transfer_scoreboard    sb = new();
   xmcrc_pkg::result_type observed;
   int                    items_sent = 0;
   int                    steady_items = 0;
   int                    stall_left = 0;
   int                    steady_cycles = 0;
   int                    idle_cycles = 0;

   xmodem_crc_receiver_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_data_offset    (rsp_data_offset),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_packet_ok      (rsp_packet_ok),
      .rsp_erase_request  (rsp_erase_request),
      .rsp_packet_address (rsp_packet_address),
      .rsp_session        (rsp_session),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sender gap: mostly none or short, a few long, sometimes a steady run
   function automatic int pick_gap();
      int roll;
      if (steady_items > 0) begin
         steady_items--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         steady_items = $urandom_range(30, 150);
         return 0;
      end
      if (roll < 6) begin
         return $urandom_range(12, 40);
      end
      if (roll < 35) begin
         return $urandom_range(1, 3);
      end
      return 0;
   endfunction

   // Result-side stall pattern, changed at the falling edge
   always @(negedge clock) begin
      int roll;
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (steady_cycles > 0) begin
         steady_cycles--;
         rsp_stall <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            steady_cycles = $urandom_range(20, 100);
            rsp_stall <= 1'b0;
         end else if (roll < 6) begin
            stall_left = $urandom_range(14, 39);
            rsp_stall <= 1'b1;
         end else if (roll < 30) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_item(req_kind, req_byte_value);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = {rsp_data_valid, rsp_data_byte, rsp_data_offset, rsp_reply_valid,
                     rsp_reply_byte, rsp_packet_end, rsp_packet_ok, rsp_erase_request,
                     rsp_packet_address, rsp_session, rsp_last};
         sb.check_result(observed);
      end
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One input transaction; entered and left at a falling edge
   task automatic send_item(logic [1:0] kind, logic [7:0] value);
      int gap;
      gap = pick_gap();
      items_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off input until every expected result is out and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic index, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      if (index == xmcrc_pkg::CSR_MAX_ERRORS) begin
         sb.error_limit = value[7:0];
      end else begin
         sb.base_address = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Full packet with random data; a flaw spoils one check or breaks it off by timeout
   task automatic send_packet(bit is_long, flaw_type flaw);
      logic [7:0]  frame[];
      logic [15:0] crc;
      int          size;
      int          cut;
      size  = is_long ? xmcrc_pkg::LONG_PACKET_BYTES : xmcrc_pkg::SHORT_PACKET_BYTES;
      frame = new[size + 5];
      frame[0] = is_long ? xmcrc_pkg::BYTE_STX : xmcrc_pkg::BYTE_SOH;
      frame[1] = sb.next_number;
      if (flaw == FLAW_NUMBER) begin
         frame[1] = frame[1] + 8'($urandom_range(1, 255));
      end
      frame[2] = ~frame[1];
      if (flaw == FLAW_COMPLEMENT) begin
         frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
      end
      crc = '0;
      for (int i = 0; i < size; i++) begin
         frame[i + 3] = 8'($urandom);
         crc = sb.crc16_step(crc, frame[i + 3]);
      end
      if (flaw == FLAW_CRC) begin
         crc = crc ^ 16'($urandom_range(1, 65535));
      end
      frame[size + 3] = crc[15:8];
      frame[size + 4] = crc[7:0];
      cut = size + 5;
      if (flaw == FLAW_TIMEOUT) begin
         cut = (!is_long && $urandom_range(0, 3) == 0) ? $urandom_range(1, size + 4)
                                                       : $urandom_range(1, 12);
      end
      for (int i = 0; i < cut; i++) begin
         send_item(xmcrc_pkg::KIND_BYTE, frame[i]);
      end
      if (cut < size + 5) begin
         send_item(xmcrc_pkg::KIND_TIMEOUT, 8'($urandom));
      end
   endtask

   // Random traffic: mostly packets, the rest header noise and session events
   task automatic send_random_step();
      int       roll;
      flaw_type flaw;
      roll = $urandom_range(0, 99);
      if (sb.session_over()) begin
         if (roll < 8) begin
            send_item(KIND_UNUSED, 8'($urandom));
         end else if (roll < 16) begin
            send_item(xmcrc_pkg::KIND_TIMEOUT, 8'($urandom));
         end else if (roll < 25) begin
            send_item(xmcrc_pkg::KIND_BYTE, 8'($urandom));
         end else begin
            send_item(xmcrc_pkg::KIND_RESTART, 8'($urandom));
         end
      end else if (roll < 60) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            flaw = FLAW_NONE;
         end else if (roll < 70) begin
            flaw = FLAW_TIMEOUT;
         end else if (roll < 80) begin
            flaw = FLAW_NUMBER;
         end else if (roll < 90) begin
            flaw = FLAW_COMPLEMENT;
         end else begin
            flaw = FLAW_CRC;
         end
         if ($urandom_range(0, 99) < 4) begin
            send_packet(1'b1, FLAW_TIMEOUT);
         end else begin
            send_packet(1'b0, flaw);
         end
      end else if (roll < 70) begin
         send_item(xmcrc_pkg::KIND_TIMEOUT, 8'($urandom));
      end else if (roll < 80) begin
         send_item(xmcrc_pkg::KIND_BYTE, 8'($urandom));
      end else if (roll < 84) begin
         send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_EOT);
      end else if (roll < 87) begin
         send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_CAN);
      end else if (roll < 92) begin
         send_item(xmcrc_pkg::KIND_RESTART, 8'($urandom));
      end else if (roll < 95) begin
         send_item(KIND_UNUSED, 8'($urandom));
      end else if (roll < 97) begin
         drain_results();
      end else begin
         send_item(xmcrc_pkg::KIND_BYTE, 8'($urandom));
      end
   endtask

   initial begin
      logic [7:0] noise;
      int         target;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: 'C' before the first packet, unknown header, break-off, abort, EOT, CAN
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);
      send_item(KIND_UNUSED, 8'hA5);
      send_item(xmcrc_pkg::KIND_BYTE, 8'hFF);
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'hFF);
      send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_SOH);
      send_item(xmcrc_pkg::KIND_BYTE, sb.next_number);
      send_item(xmcrc_pkg::KIND_BYTE, ~sb.next_number);
      send_item(xmcrc_pkg::KIND_BYTE, 8'h00);
      send_item(xmcrc_pkg::KIND_BYTE, 8'hFF);
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);
      send_item(xmcrc_pkg::KIND_BYTE, 8'h00);
      send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_SOH);
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);
      send_item(xmcrc_pkg::KIND_RESTART, 8'h00);
      send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_EOT);
      send_item(KIND_UNUSED, 8'h00);
      send_item(xmcrc_pkg::KIND_RESTART, 8'hFF);
      send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_CAN);
      send_item(xmcrc_pkg::KIND_RESTART, 8'h00);
      send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::BYTE_STX);
      send_item(xmcrc_pkg::KIND_BYTE, sb.next_number);
      send_item(xmcrc_pkg::KIND_BYTE, ~sb.next_number);
      send_item(xmcrc_pkg::KIND_BYTE, 8'h80);
      send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);

      // Reset register values
      while (items_sent < 60) send_random_step();

      // Highest error limit, address that wraps; one full long and one full short packet, then errors to abort
      drain_results();
      write_register(xmcrc_pkg::CSR_MAX_ERRORS, 32'd255);
      write_register(xmcrc_pkg::CSR_START_ADDRESS, 32'hFFFF_FF80);
      send_item(xmcrc_pkg::KIND_RESTART, 8'h00);
      send_packet(1'b1, FLAW_NONE);
      send_packet(1'b0, FLAW_NONE);
      while (!sb.session_over()) begin
         do begin
            noise = 8'($urandom);
         end while (noise == xmcrc_pkg::BYTE_SOH || noise == xmcrc_pkg::BYTE_STX ||
                    noise == xmcrc_pkg::BYTE_EOT || noise == xmcrc_pkg::BYTE_CAN);
         send_item(xmcrc_pkg::KIND_BYTE, noise);
      end
      send_item(xmcrc_pkg::KIND_RESTART, 8'h00);
      target = items_sent + 40;
      while (items_sent < target) send_random_step();

      // Lowest error limit, top address
      drain_results();
      write_register(xmcrc_pkg::CSR_MAX_ERRORS, 32'd1);
      write_register(xmcrc_pkg::CSR_START_ADDRESS, 32'hFFFF_FFFF);
      send_item(xmcrc_pkg::KIND_RESTART, 8'h00);
      target = items_sent + 40;
      while (items_sent < target) send_random_step();

      // New address only takes hold at the next restart
      drain_results();
      write_register(xmcrc_pkg::CSR_MAX_ERRORS, 32'($urandom_range(2, 8)));
      write_register(xmcrc_pkg::CSR_START_ADDRESS, $urandom);
      target = items_sent + 40;
      while (items_sent < target) send_random_step();

      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
